// ----- sv/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int ItemWidth     = 32;
    localparam int PrioWidth     = 8;
    localparam int OccWidth      = 7;
    localparam int SizeWidth     = 7;

    localparam logic [SizeWidth-1:0] QUEUE_SIZE_RESET = 7'd64;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // one stored entry as handed between neighboring cells
    typedef struct packed {
        logic                 occ;
        logic [ItemWidth-1:0] item;
        logic [PrioWidth-1:0] prio;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                 enq;
        logic                 deq;
        logic [ItemWidth-1:0] item;
        logic [PrioWidth-1:0] prio;
    } cmd_t;

endpackage

// ----- sv/spq_if.sv -----
// channel interfaces for the sorted priority queue
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] item_value;
    logic [7:0]  item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] removed_item;
    logic [6:0]  occupancy;

    modport source (output valid, output status, output removed_item,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input removed_item,
                    input occupancy, output ready);
endinterface

interface spq_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] queue_size;

    modport source (output valid, output queue_size, input ready);
    modport sink   (input valid, input queue_size, output ready);
endinterface

// ----- sv/spq_cell.sv -----
// one slot of the sorted chain: keeps, takes the new entry, or shifts
module spq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  spq_pkg::cmd_t   cmd,
    input  spq_pkg::entry_t prev_entry,
    input  logic           prev_less,
    input  spq_pkg::entry_t next_entry,
    output spq_pkg::entry_t entry,
    output logic           less
);

    logic                          occ_reg;
    logic                          occ_next;
    logic [spq_pkg::ItemWidth-1:0] item_reg;
    logic [spq_pkg::ItemWidth-1:0] item_next;
    logic [spq_pkg::PrioWidth-1:0] prio_reg;
    logic [spq_pkg::PrioWidth-1:0] prio_next;

    assign entry = '{occ: occ_reg, item: item_reg, prio: prio_reg};

    // entry stays ahead of a new one with larger priority; a new one with equal priority goes ahead
    assign less = occ_reg && (prio_reg < cmd.prio);

    always_comb
    begin
        occ_next  = occ_reg;
        item_next = item_reg;
        prio_next = prio_reg;
        if (cmd.enq)
        begin
            if (less)
            begin
                occ_next = occ_reg;
            end
            else if (prev_less)
            begin
                occ_next  = 1'b1;
                item_next = cmd.item;
                prio_next = cmd.prio;
            end
            else
            begin
                occ_next  = prev_entry.occ;
                item_next = prev_entry.item;
                prio_next = prev_entry.prio;
            end
        end
        else if (cmd.deq)
        begin
            occ_next  = next_entry.occ;
            item_next = next_entry.item;
            prio_next = next_entry.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prio_reg <= prio_next;
    end

endmodule

// ----- sv/sorted_priority_queue_core.sv -----
// Sorted priority queue built as a chain of entry cells.
// in_ch carries one operation per transfer: enqueue (item_value, item_priority)
// or dequeue of the head. out_ch returns one result per input transfer:
// status, removed_item and the occupancy after the operation.
// cfg_ch writes queue_size, the entry limit (values above CAPACITY act as
// CAPACITY); it is always ready; the user must write it only while the queue is idle.
// The block does not enforce that. Every cell compares the broadcast priority
// with its own entry and either keeps it, takes the new entry or takes its
// neighbor's, so insert and remove take the same time whatever the occupancy.
// The result is registered and appears on out_ch in the cycle after the
// input transfer. Throughput: one item per cycle while the receiver takes
// results; the single output register sets that figure.
// When out_ch stalls, in_ch.ready drops until the held result is taken.
// Reset empties the queue, clears the output valid flag and sets queue_size
// to 64; stored entries need no clearing.
module sorted_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_in_if.sink     in_ch,
    spq_out_if.source  out_ch,
    spq_cfg_if.sink    cfg_ch
);

    localparam int CountWidth = $clog2(CAPACITY + 1);
    localparam int LimWidth   = (CountWidth > spq_pkg::SizeWidth) ?
                                CountWidth : spq_pkg::SizeWidth;

    logic [spq_pkg::SizeWidth-1:0] queue_size_reg;
    logic [CountWidth-1:0]         count_reg;
    logic [CountWidth-1:0]         count_next;
    logic                          out_valid_reg;
    spq_pkg::status_t              status_reg;
    spq_pkg::status_t              status_next;
    logic [spq_pkg::ItemWidth-1:0] removed_reg;
    logic [spq_pkg::ItemWidth-1:0] removed_next;
    logic [spq_pkg::OccWidth-1:0]  occ_reg;

    logic                          in_xfer;
    logic                          full;
    logic                          empty;
    logic [LimWidth-1:0]           count_ext;
    logic [LimWidth-1:0]           size_ext;
    logic [LimWidth-1:0]           limit;
    logic [LimWidth-1:0]           count_next_ext;
    spq_pkg::cmd_t                 cmd;

    spq_pkg::entry_t               cell_entry [CAPACITY];
    logic                          cell_less  [CAPACITY];

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    assign count_ext = LimWidth'(count_reg);
    assign size_ext  = LimWidth'(queue_size_reg);
    assign limit     = (size_ext > LimWidth'(CAPACITY)) ? LimWidth'(CAPACITY) : size_ext;
    assign full      = count_ext >= limit;
    assign empty     = (count_reg == '0);

    assign cmd.enq  = in_xfer && (in_ch.operation == spq_pkg::OP_ENQUEUE) && !full;
    assign cmd.deq  = in_xfer && (in_ch.operation == spq_pkg::OP_DEQUEUE) && !empty;
    assign cmd.item = in_ch.item_value;
    assign cmd.prio = in_ch.item_priority;

    always_comb
    begin
        count_next   = count_reg;
        status_next  = spq_pkg::STATUS_OK;
        removed_next = '0;
        if (in_ch.operation == spq_pkg::OP_ENQUEUE)
        begin
            if (full)
            begin
                status_next = spq_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CountWidth'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                removed_next = cell_entry[0].item;
                count_next   = count_reg - CountWidth'(1);
            end
        end
    end

    assign count_next_ext = LimWidth'(count_next);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t prev_entry;
        spq_pkg::entry_t next_entry;
        logic            prev_less;

        if (i == 0)
        begin : g_head
            // the head has nothing ahead of it
            assign prev_entry = '{occ: 1'b1, item: '0, prio: '0};
            assign prev_less  = 1'b1;
        end
        else
        begin : g_mid
            assign prev_entry = cell_entry[i-1];
            assign prev_less  = cell_less[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = '{occ: 1'b0, item: '0, prio: '0};
        end
        else
        begin : g_body
            assign next_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_entry (prev_entry),
            .prev_less  (prev_less),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .less       (cell_less[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_size_reg <= spq_pkg::QUEUE_SIZE_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                queue_size_reg <= cfg_ch.queue_size;
            end
            if (in_xfer)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            occ_reg     <= count_next_ext[spq_pkg::OccWidth-1:0];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.removed_item = removed_reg;
    assign out_ch.occupancy    = occ_reg;

endmodule

// ----- sv/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] removed_item,
    input logic [6:0]  occupancy
);

    // every input transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // a refused dequeue reports an empty queue and no item
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::STATUS_EMPTY) |->
            (occupancy == 7'd0) && (removed_item == 32'd0))
        else $error("empty status with entries or item");

    // a refused enqueue carries no item
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::STATUS_FULL) |-> (removed_item == 32'd0))
        else $error("full status with nonzero item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(status) && $stable(removed_item) && $stable(occupancy))
        else $error("result changed while stalled");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .removed_item (out_ch.removed_item),
    .occupancy    (out_ch.occupancy)
);

// ----- dv/sorted_priority_queue_core_tb.sv -----
`timescale 1ns / 100ps
// testbench for the sorted priority queue core, checked against a shadow sorted queue
module sorted_priority_queue_core_tb;

    localparam int QueueCapacity = 64;

    typedef struct {
        logic [spq_pkg::ItemWidth-1:0] item;
        logic [spq_pkg::PrioWidth-1:0] prio;
    } slot_t;

    typedef struct {
        spq_pkg::status_t              status;
        logic [spq_pkg::ItemWidth-1:0] removed;
        logic [spq_pkg::OccWidth-1:0]  occupancy;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();
    spq_cfg_if cfg_ch ();

    sorted_priority_queue_core #(
        .CAPACITY (QueueCapacity)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    slot_t                         shadow_slots[$];
    result_t                       expected_results[$];
    result_t                       due_result;
    logic [spq_pkg::SizeWidth-1:0] shadow_queue_size = spq_pkg::QUEUE_SIZE_RESET;
    int                            error_count = 0;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;

    always #4 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // shadow of the sorted array: insert ahead of equal priorities, remove at head
    function automatic void predict_queue_op(logic op, logic [spq_pkg::ItemWidth-1:0] item,
                                             logic [spq_pkg::PrioWidth-1:0] prio);
        result_t res;
        slot_t   entry;
        int      limit;
        int      pos;
        limit = (shadow_queue_size > QueueCapacity) ? QueueCapacity : int'(shadow_queue_size);
        res.status  = spq_pkg::STATUS_OK;
        res.removed = '0;
        if (op == spq_pkg::OP_ENQUEUE)
        begin
            if (shadow_slots.size() >= limit)
                res.status = spq_pkg::STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_slots.size() && shadow_slots[pos].prio < prio)
                    pos++;
                entry.item = item;
                entry.prio = prio;
                shadow_slots.insert(pos, entry);
            end
        end
        else if (shadow_slots.size() == 0)
            res.status = spq_pkg::STATUS_EMPTY;
        else
        begin
            entry = shadow_slots.pop_front();
            res.removed = entry.item;
        end
        res.occupancy = spq_pkg::OccWidth'(shadow_slots.size());
        expected_results.push_back(res);
    endfunction

    task automatic send_op(logic op, logic [spq_pkg::ItemWidth-1:0] item,
                           logic [spq_pkg::PrioWidth-1:0] prio);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.item_value    <= item;
        in_ch.item_priority <= prio;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_queue_op(op, item, prio);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_queue_size(logic [spq_pkg::SizeWidth-1:0] value);
        wait_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.queue_size <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        shadow_queue_size = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls and field-by-field compare on each transfer
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result: status %0d removed %h occupancy %0d",
                                          out_ch.status, out_ch.removed_item, out_ch.occupancy));
            else
            begin
                due_result = expected_results.pop_front();
                if (out_ch.status !== due_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_ch.status, due_result.status));
                if (out_ch.removed_item !== due_result.removed)
                    report_mismatch($sformatf("removed_item %h, expected %h",
                                              out_ch.removed_item, due_result.removed));
                if (out_ch.occupancy !== due_result.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              out_ch.occupancy, due_result.occupancy));
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // extreme items and priorities, ties, empty dequeue with ignored fields set
    task automatic test_directed_order();
        send_op(spq_pkg::OP_DEQUEUE, '1, '1);
        send_op(spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 8'd255);
        send_op(spq_pkg::OP_ENQUEUE, 32'h8000_0000, 8'd0);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 8'd128);
        send_op(spq_pkg::OP_ENQUEUE, 32'h1111_1111, 8'd8);
        send_op(spq_pkg::OP_ENQUEUE, 32'h2222_2222, 8'd8);
        send_op(spq_pkg::OP_ENQUEUE, 32'h3333_3333, 8'd8);
        send_op(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 8'd1);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0005, 8'd255);
        send_op(spq_pkg::OP_DEQUEUE, '0, '0);
        repeat (7)
            send_op(spq_pkg::OP_DEQUEUE, '1, '1);
        send_op(spq_pkg::OP_DEQUEUE, '0, '0);
    endtask

    // zero limit, limit of one, limit lowered under the stored count
    task automatic test_limit_edges();
        write_queue_size(7'd0);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0001, 8'd0);
        send_op(spq_pkg::OP_DEQUEUE, '0, '0);
        write_queue_size(7'd1);
        send_op(spq_pkg::OP_ENQUEUE, 32'hA5A5_A5A5, 8'd3);
        send_op(spq_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 8'd2);
        send_op(spq_pkg::OP_DEQUEUE, '0, '0);
        write_queue_size(spq_pkg::QUEUE_SIZE_RESET);
        repeat (5)
            send_op(spq_pkg::OP_ENQUEUE, $urandom, 8'($urandom_range(3)));
        write_queue_size(7'd2);
        send_op(spq_pkg::OP_ENQUEUE, $urandom, 8'd0);
        repeat (5)
            send_op(spq_pkg::OP_DEQUEUE, $urandom, 8'($urandom));
        send_op(spq_pkg::OP_ENQUEUE, $urandom, 8'd200);
    endtask

    // bursts that push toward full or empty, with narrow priority bands for ties
    task automatic random_phase(logic [spq_pkg::SizeWidth-1:0] size, int idle_pct,
                                int stall_pct, int num_items);
        int                            sent;
        int                            burst_left;
        int                            enq_pct;
        logic                          op;
        logic [spq_pkg::PrioWidth-1:0] prio;
        write_queue_size(size);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent       = 0;
        burst_left = 0;
        enq_pct    = 50;
        while (sent < num_items)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(120, 10);
                case ($urandom_range(2))
                    0:       enq_pct = 90;
                    1:       enq_pct = 15;
                    default: enq_pct = 55;
                endcase
                // hold off now and then until every result is back
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
            op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
            case ($urandom_range(2))
                0:       prio = 8'($urandom_range(7));
                1:       prio = 8'($urandom_range(255, 248));
                default: prio = 8'($urandom);
            endcase
            send_op(op, $urandom, prio);
            burst_left--;
            sent++;
        end
    endtask

    task automatic test_random_traffic();
        random_phase(7'd127, 0, 0, 450);
        random_phase(7'd64, 85, 0, 300);
        random_phase(7'd3, 0, 85, 250);
        random_phase(7'd100, 38, 38, 450);
        random_phase(7'd1, 0, 0, 100);
        random_phase(spq_pkg::QUEUE_SIZE_RESET, 0, 0, 150);
    endtask

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.operation     = spq_pkg::OP_ENQUEUE;
        in_ch.item_value    = '0;
        in_ch.item_priority = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.queue_size   = spq_pkg::QUEUE_SIZE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_order();
        test_limit_edges();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
